@@ design/crypto1_pkg.sv @@
// Shared types, constants, filter function and key loader of the Crypto1 keystream engine.
package crypto1_pkg;

  localparam int unsigned HalfW = 24;
  localparam int unsigned KeyW  = 48;

  localparam logic [HalfW-1:0] PolyOdd  = 24'h29CE5C;
  localparam logic [HalfW-1:0] PolyEven = 24'h870804;

  typedef enum logic [2:0] {
    CMD_LOAD      = 3'd0,
    CMD_BIT       = 3'd1,
    CMD_BYTE      = 3'd2,
    CMD_WORD      = 3'd3,
    CMD_BACK_BIT  = 3'd4,
    CMD_BACK_WORD = 3'd5,
    CMD_RECOVER   = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic [HalfW-1:0] odd;
    logic [HalfW-1:0] even;
  } lfsr_t;

  typedef struct packed {
    logic backward;
    logic in_bit;
    logic fb;
  } step_ctl_t;

  function automatic logic filter_bit(input logic [HalfW-1:0] v);
    logic [19:0] fa;
    logic [19:0] fb;
    logic [19:0] fc;
    logic [19:0] fd;
    logic [19:0] fe;
    logic [31:0] fo;
    logic [4:0]  idx;
    fa = 20'hf22c0;
    fb = 20'h6c9c0;
    fc = 20'h3c8b0;
    fd = 20'h1e458;
    fe = 20'h0d938;
    fo = 32'hEC57E80A;
    idx[4] = fa[{1'b0, v[3:0]} + 5'd4];
    idx[3] = fb[{1'b0, v[7:4]} + 5'd3];
    idx[2] = fc[{1'b0, v[11:8]} + 5'd2];
    idx[1] = fd[{1'b0, v[15:12]} + 5'd1];
    idx[0] = fe[{1'b0, v[19:16]}];
    return fo[idx];
  endfunction

  function automatic lfsr_t load_key(input logic [KeyW-1:0] key);
    lfsr_t s;
    for (int k = 0; k < HalfW; k++) begin
      s.odd[k]  = key[(2 * k) ^ 7];
      s.even[k] = key[(2 * k + 1) ^ 7];
    end
    return s;
  endfunction

endpackage

@@ design/crypto1_stream_cipher.sv @@
// Top level of the Crypto1 keystream engine: stream ports, sequencer and LFSR state.
//
// Each beat on the input carries one command, and each command gives one result beat.
// The LFSR moves one bit per cycle through a single shared step unit; a command that
// clocks n bits (n is 1, 8 or 32; load and the unused code take no step) keeps the
// block busy while it steps and then until its result is placed in the output register,
// which waits while an earlier result has not been taken. Input ready drops during that
// time and returns as soon as the result is registered, even while it still waits to be
// taken. Nonce recovery runs 32 steps on a private copy and leaves the main state as is.
module crypto1_stream_cipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [47:0] cfg_wdata_i,     // cipher_key
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // data_in [31:0], uid_in [63:32]
  input  logic [3:0]  s_axis_tuser_i,  // command [2:0], feedback_enable [3]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // keystream_out [31:0]
  output logic [0:0]  m_axis_tuser_o   // parity_keystream [0]
);

  crypto1_pkg::state_e    state_q, state_d;
  crypto1_pkg::cmd_e      cmd_q;
  crypto1_pkg::lfsr_t     main_q;
  crypto1_pkg::lfsr_t     work_q;
  crypto1_pkg::lfsr_t     step_next;
  crypto1_pkg::step_ctl_t step_ctl;
  logic [crypto1_pkg::KeyW-1:0] key_q;
  logic [31:0] data_q;
  logic [31:0] uid_q;
  logic [31:0] ks_q;
  logic        fb_q;
  logic [4:0]  cnt_q;
  logic [4:0]  last_q;
  logic [4:0]  pos;
  logic        step_ks;
  logic        in_acc;
  logic        out_free;
  logic        last_step;
  logic        step_en;
  logic        out_load;
  logic        commit;
  logic        is_recover;
  logic        m_valid_q;
  logic [31:0] m_data_q;
  logic        m_par_q;
  crypto1_pkg::cmd_e in_cmd;

  assign in_cmd     = crypto1_pkg::cmd_e'(s_axis_tuser_i[2:0]);
  assign in_acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free   = !m_valid_q || m_axis_tready_i;
  assign last_step  = (cnt_q == last_q);
  assign is_recover = (cmd_q == crypto1_pkg::CMD_RECOVER);

  always_comb begin
    state_d = state_q;
    case (state_q)
      crypto1_pkg::ST_IDLE: if (in_acc) state_d = crypto1_pkg::ST_RUN;
      crypto1_pkg::ST_RUN:  if (last_step) state_d = crypto1_pkg::ST_HOLD;
      crypto1_pkg::ST_HOLD: if (out_free) state_d = crypto1_pkg::ST_IDLE;
      default:              state_d = crypto1_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    step_en         = 1'b0;
    out_load        = 1'b0;
    case (state_q)
      crypto1_pkg::ST_IDLE: s_axis_tready_o = 1'b1;
      crypto1_pkg::ST_RUN: begin
        case (cmd_q)
          crypto1_pkg::CMD_BIT, crypto1_pkg::CMD_BYTE, crypto1_pkg::CMD_WORD,
          crypto1_pkg::CMD_BACK_BIT, crypto1_pkg::CMD_BACK_WORD,
          crypto1_pkg::CMD_RECOVER: step_en = 1'b1;
          default:                  step_en = 1'b0;
        endcase
      end
      crypto1_pkg::ST_HOLD: out_load = out_free;
      default: ;
    endcase
  end

  assign commit = out_load && !is_recover;

  always_comb begin
    case (cmd_q)
      crypto1_pkg::CMD_BYTE:      pos = cnt_q;
      crypto1_pkg::CMD_WORD:      pos = cnt_q ^ 5'd24;
      crypto1_pkg::CMD_RECOVER:   pos = cnt_q ^ 5'd24;
      crypto1_pkg::CMD_BACK_WORD: pos = ~cnt_q ^ 5'd24;
      default:                    pos = 5'd0;
    endcase
  end

  assign step_ctl.backward = (cmd_q == crypto1_pkg::CMD_BACK_BIT) ||
                             (cmd_q == crypto1_pkg::CMD_BACK_WORD);
  assign step_ctl.in_bit   = data_q[pos] ^ (is_recover & uid_q[pos]);
  assign step_ctl.fb       = is_recover | fb_q;

  crypto1_step u_step (
    .state_i (work_q),
    .ctl_i   (step_ctl),
    .state_o (step_next),
    .ks_o    (step_ks)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= crypto1_pkg::ST_IDLE;
      key_q     <= '0;
      main_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) key_q <= cfg_wdata_i;
      if (commit) main_q <= work_q;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q  <= in_cmd;
      data_q <= s_axis_tdata_i[31:0];
      uid_q  <= s_axis_tdata_i[63:32];
      fb_q   <= s_axis_tuser_i[3];
      cnt_q  <= '0;
      ks_q   <= '0;
      case (in_cmd)
        crypto1_pkg::CMD_BYTE:      last_q <= 5'd7;
        crypto1_pkg::CMD_WORD,
        crypto1_pkg::CMD_BACK_WORD,
        crypto1_pkg::CMD_RECOVER:   last_q <= 5'd31;
        default:                    last_q <= 5'd0;
      endcase
      if (in_cmd == crypto1_pkg::CMD_LOAD || in_cmd == crypto1_pkg::CMD_RECOVER) begin
        work_q <= crypto1_pkg::load_key(key_q);
      end else begin
        work_q <= main_q;
      end
    end else if (state_q == crypto1_pkg::ST_RUN) begin
      if (step_en) begin
        work_q    <= step_next;
        ks_q[pos] <= step_ks;
      end
      if (!last_step) cnt_q <= cnt_q + 5'd1;
    end
    if (out_load) begin
      m_data_q <= is_recover ? (data_q ^ ks_q) : ks_q;
      m_par_q  <= crypto1_pkg::filter_bit(commit ? work_q.odd : main_q.odd);
    end
  end

  assign m_axis_tvalid_o   = m_valid_q;
  assign m_axis_tdata_o    = m_data_q;
  assign m_axis_tuser_o[0] = m_par_q;

endmodule

@@ design/crypto1_step.sv @@
// One forward or backward bit step of the Crypto1 LFSR with its filter output.
module crypto1_step (
  input  crypto1_pkg::lfsr_t     state_i,
  input  crypto1_pkg::step_ctl_t ctl_i,
  output crypto1_pkg::lfsr_t     state_o,
  output logic                   ks_o
);

  logic                         ks_fwd;
  logic                         ks_back;
  logic                         feed_fwd;
  logic                         feed_back;
  logic [crypto1_pkg::HalfW-2:0] shr;

  assign ks_fwd  = crypto1_pkg::filter_bit(state_i.odd);
  assign ks_back = crypto1_pkg::filter_bit(state_i.even);
  assign shr     = state_i.odd[crypto1_pkg::HalfW-1:1];

  assign feed_fwd = (ks_fwd & ctl_i.fb) ^ ctl_i.in_bit
                  ^ (^(crypto1_pkg::PolyOdd & state_i.odd))
                  ^ (^(crypto1_pkg::PolyEven & state_i.even));

  assign feed_back = state_i.odd[0]
                   ^ (^(crypto1_pkg::PolyEven & {1'b0, shr}))
                   ^ (^(crypto1_pkg::PolyOdd & state_i.even))
                   ^ ctl_i.in_bit ^ (ks_back & ctl_i.fb);

  always_comb begin
    if (ctl_i.backward) begin
      state_o.odd  = state_i.even;
      state_o.even = {feed_back, shr};
      ks_o         = ks_back;
    end else begin
      state_o.odd  = {state_i.even[crypto1_pkg::HalfW-2:0], feed_fwd};
      state_o.even = state_i.odd;
      ks_o         = ks_fwd;
    end
  end

endmodule

@@ design/crypto1_checker.sv @@
// Port-level assertions for the Crypto1 keystream engine and their bind.
module crypto1_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [0:0]  m_axis_tuser_o
);

  logic in_beat;
  assign in_beat = s_axis_tvalid_i && s_axis_tready_o;

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !s_axis_tready_o)
    else $error("input ready high right after an accepted beat");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !$rose(m_axis_tvalid_o))
    else $error("result appeared one cycle after its command");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output valid dropped while stalled");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output beat changed while stalled");

endmodule

bind crypto1_stream_cipher crypto1_checker u_crypto1_checker (.*);

@@ dv/crypto1_keystream_checker.sv @@
// Keystream predictor and result checker for the Crypto1 stream cipher testbench.
module crypto1_keystream_checker
  import crypto1_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [47:0] cfg_wdata_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [63:0] s_tdata_i,
  input  logic [3:0]  s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,
  input  logic [0:0]  m_tuser_i,
  output int          mismatches_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] keystream;
    logic        parity;
  } ks_result_t;

  logic [KeyW-1:0] sector_key   = '0;
  lfsr_t           cipher_state = '0;
  ks_result_t      keystream_q[$];
  ks_result_t      oldest;
  int              mismatches   = 0;

  function automatic logic nlf_out(input logic [HalfW-1:0] v);
    logic [31:0] t;
    logic [4:0]  idx;
    t = 32'h000f22c0 >> v[3:0];
    idx[4] = t[4];
    t = 32'h0006c9c0 >> v[7:4];
    idx[3] = t[3];
    t = 32'h0003c8b0 >> v[11:8];
    idx[2] = t[2];
    t = 32'h0001e458 >> v[15:12];
    idx[1] = t[1];
    t = 32'h0000d938 >> v[19:16];
    idx[0] = t[0];
    t = 32'hEC57E80A >> idx;
    return t[0];
  endfunction

  function automatic lfsr_t key_to_halves(input logic [KeyW-1:0] key);
    lfsr_t s;
    s = '0;
    for (int i = 47; i > 0; i -= 2) begin
      s.odd  = {s.odd[HalfW-2:0], key[(i - 1) ^ 7]};
      s.even = {s.even[HalfW-2:0], key[i ^ 7]};
    end
    return s;
  endfunction

  function automatic logic clock_fwd(inout lfsr_t s, input logic din, input logic fb);
    logic             ks;
    logic             feed;
    logic [HalfW-1:0] prev_odd;
    ks = nlf_out(s.odd);
    feed = (ks & fb) ^ din ^ (^(s.odd & PolyOdd)) ^ (^(s.even & PolyEven));
    prev_odd = s.odd;
    s.odd = {s.even[HalfW-2:0], feed};
    s.even = prev_odd;
    return ks;
  endfunction

  function automatic logic clock_back(inout lfsr_t s, input logic din, input logic fb);
    logic             ks;
    logic             x;
    logic [HalfW-1:0] shifted;
    x = s.odd[0];
    shifted = {1'b0, s.odd[HalfW-1:1]};
    s.odd = s.even;
    ks = nlf_out(s.odd);
    x = x ^ (^(shifted & PolyEven)) ^ (^(s.odd & PolyOdd)) ^ din ^ (ks & fb);
    s.even = {x, shifted[HalfW-2:0]};
    return ks;
  endfunction

  // Bytes of a word are taken in reversed order, bits within a byte in natural order.
  function automatic logic [31:0] word_fwd(inout lfsr_t s, input logic [31:0] din,
                                           input logic fb);
    logic [31:0] ks;
    logic [4:0]  p;
    ks = '0;
    for (int i = 0; i < 32; i++) begin
      p = 5'(i) ^ 5'd24;
      ks[p] = clock_fwd(s, din[p], fb);
    end
    return ks;
  endfunction

  function automatic ks_result_t predict_keystream(input logic [2:0] cmd,
                                                   input logic [31:0] din,
                                                   input logic [31:0] uid,
                                                   input logic fb);
    ks_result_t r;
    lfsr_t      scratch;
    logic [4:0] p;
    r = '0;
    case (cmd)
      CMD_LOAD: cipher_state = key_to_halves(sector_key);
      CMD_BIT: r.keystream[0] = clock_fwd(cipher_state, din[0], fb);
      CMD_BYTE: begin
        for (int i = 0; i < 8; i++) r.keystream[i] = clock_fwd(cipher_state, din[i], fb);
      end
      CMD_WORD: r.keystream = word_fwd(cipher_state, din, fb);
      CMD_BACK_BIT: r.keystream[0] = clock_back(cipher_state, din[0], fb);
      CMD_BACK_WORD: begin
        for (int i = 31; i >= 0; i--) begin
          p = 5'(i) ^ 5'd24;
          r.keystream[p] = clock_back(cipher_state, din[p], fb);
        end
      end
      CMD_RECOVER: begin
        scratch = key_to_halves(sector_key);
        r.keystream = din ^ word_fwd(scratch, din ^ uid, 1'b1);
      end
      default: ;
    endcase
    r.parity = nlf_out(cipher_state.odd);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sector_key = '0;
      cipher_state = '0;
      keystream_q.delete();
    end else begin
      if (cfg_we_i) sector_key = cfg_wdata_i;
      if (s_tvalid_i && s_tready_i) begin
        keystream_q.push_back(predict_keystream(s_tuser_i[2:0], s_tdata_i[31:0],
                                                s_tdata_i[63:32], s_tuser_i[3]));
      end
      if (m_tvalid_i && m_tready_i) begin
        if (keystream_q.size() == 0) begin
          $error("Result beat arrived with no command outstanding.");
          mismatches++;
        end else begin
          oldest = keystream_q.pop_front();
          if (m_tdata_i !== oldest.keystream) begin
            $error("keystream_out: expected %h, actual %h", oldest.keystream, m_tdata_i);
            mismatches++;
          end
          if (m_tuser_i[0] !== oldest.parity) begin
            $error("parity_keystream: expected %b, actual %b", oldest.parity, m_tuser_i[0]);
            mismatches++;
          end
        end
      end
    end
    mismatches_o = mismatches;
    pending_o = keystream_q.size();
  end

endmodule

@@ dv/crypto1_stream_cipher_tb.sv @@
// Top of the Crypto1 stream cipher testbench: clock, reset, stimulus and verdict.
module crypto1_stream_cipher_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import crypto1_pkg::*;

  localparam logic [2:0] CmdUnused   = 3'd7;
  localparam int         QuietLimit  = 4000;
  localparam int         PhaseItems  = 375;
  localparam int         NumPhases   = 5;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [47:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [3:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [0:0]  m_tuser;

  int          mismatches;
  int          pending;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          quiet_cycles = 0;

  always #10 clk_i = ~clk_i;

  crypto1_stream_cipher uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  crypto1_keystream_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always @(negedge clk_i) m_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_cmd(input logic [2:0] cmd, input logic [31:0] din,
                          input logic [31:0] uid, input logic fb);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {uid, din};
    s_tuser <= {fb, cmd};
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_key(input logic [47:0] key);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= key;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_cmd(inout logic [2:0] prev_cmd, inout logic [31:0] prev_data,
                            inout logic prev_fb);
    int          r;
    logic [2:0]  cmd;
    logic [31:0] din;
    logic        fb;
    r = $urandom_range(99);
    din = rand_word();
    fb = 1'($urandom_range(1));
    if (r < 6) begin
      cmd = CMD_LOAD;
    end else if (r < 20) begin
      cmd = CMD_BIT;
    end else if (r < 34) begin
      cmd = CMD_BYTE;
    end else if (r < 54) begin
      cmd = CMD_WORD;
    end else if (r < 64) begin
      cmd = CMD_BACK_BIT;
    end else if (r < 76) begin
      cmd = CMD_BACK_WORD;
    end else if (r < 94) begin
      cmd = CMD_RECOVER;
    end else begin
      cmd = CmdUnused;
    end
    // Undo the previous word now and then so the rollback path retraces known states.
    if (prev_cmd == CMD_WORD && $urandom_range(3) == 0) begin
      cmd = CMD_BACK_WORD;
      din = prev_data;
      fb = prev_fb;
    end
    send_cmd(cmd, din, rand_word(), fb);
    prev_cmd = cmd;
    prev_data = din;
    prev_fb = fb;
  endtask

  initial begin
    logic [2:0]  prev_cmd;
    logic [31:0] prev_data;
    logic        prev_fb;
    int          idle_tbl[NumPhases];
    int          stall_tbl[NumPhases];
    logic [47:0] key_tbl[NumPhases];
    idle_tbl = '{0, 55, 0, 15, 0};
    stall_tbl = '{0, 0, 55, 15, 0};
    key_tbl = '{48'hFFFF_FFFF_FFFF, 48'({$urandom, $urandom}), 48'h0,
                48'({$urandom, $urandom}), 48'h0123_4567_89AB};
    prev_cmd = CMD_LOAD;
    prev_data = '0;
    prev_fb = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_cmd(CMD_LOAD, 32'h0, 32'h0, 1'b0);
    send_cmd(CMD_WORD, 32'h0, 32'h0, 1'b0);
    write_key(48'hA0A1_A2A3_A4A5);
    send_cmd(CMD_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_cmd(CMD_BIT, 32'h0000_0001, 32'h0, 1'b0);
    send_cmd(CMD_BIT, 32'h0000_0000, 32'h0, 1'b1);
    send_cmd(CMD_BIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_cmd(CMD_BYTE, 32'h0000_00A5, 32'h0, 1'b0);
    send_cmd(CMD_BYTE, 32'hFFFF_FFFF, 32'h0, 1'b1);
    send_cmd(CMD_WORD, 32'hFFFF_FFFF, 32'h0, 1'b0);
    send_cmd(CMD_WORD, 32'h1234_5678, 32'h0, 1'b1);
    send_cmd(CMD_BACK_WORD, 32'h1234_5678, 32'h0, 1'b1);
    send_cmd(CMD_BACK_BIT, 32'h0000_0001, 32'h0, 1'b1);
    send_cmd(CMD_BACK_BIT, 32'h0000_0000, 32'h0, 1'b0);
    send_cmd(CMD_BACK_WORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_cmd(CMD_RECOVER, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_cmd(CMD_RECOVER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_cmd(CMD_RECOVER, $urandom, $urandom, 1'b0);
    send_cmd(CmdUnused, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    write_key(48'hFFFF_FFFF_FFFF);
    send_cmd(CMD_LOAD, 32'h0, 32'h0, 1'b0);
    send_cmd(CMD_WORD, $urandom, 32'h0, 1'b1);
    send_cmd(CMD_RECOVER, $urandom, $urandom, 1'b0);

    for (int ph = 0; ph < NumPhases; ph++) begin
      write_key(key_tbl[ph]);
      idle_pct = idle_tbl[ph];
      stall_pct = stall_tbl[ph];
      send_cmd(CMD_LOAD, rand_word(), rand_word(), 1'b0);
      prev_cmd = CMD_LOAD;
      for (int n = 0; n < PhaseItems; n++) random_cmd(prev_cmd, prev_data, prev_fb);
    end

    drain_results();
    repeat (40) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
